FILE: src/cnlc_pkg.sv
// Shared widths and stage types for the card number Luhn classifier.
package cnlc_pkg;

    localparam int IN_W       = 54;   // binary card number width
    localparam int NUM_DIGITS = 17;   // decimal digits a 54-bit value can have
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 5;    // digit count width
    localparam int CLS_W      = 2;
    localparam int MAX_DIGITS = 16;   // longest accepted digit string

    // Card class codes
    localparam logic [CLS_W-1:0] CLS_INVALID = 2'd0;
    localparam logic [CLS_W-1:0] CLS_LEAD4   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LEAD3X  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_LEAD5X  = 2'd3;

    // Data handed from one conversion cell to the next
    typedef struct packed {
        logic [IN_W-1:0]  bin;   // binary bits still to shift in, MSB first
        logic [BCD_W-1:0] bcd;   // decimal digits built so far
    } dd_data_t;

    // One result item
    typedef struct packed {
        logic [CNT_W-1:0] digit_count;
        logic [CLS_W-1:0] card_class;
        logic             luhn_pass;
    } result_t;

endpackage

FILE: src/cnlc_dd_cell.sv
// One shift-add-3 conversion cell: moves one binary bit into the decimal digits.
module cnlc_dd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cnlc_pkg::dd_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cnlc_pkg::dd_data_t out_data
);

    logic               valid_reg;
    logic               valid_next;
    cnlc_pkg::dd_data_t data_reg;
    cnlc_pkg::dd_data_t data_next;
    logic [cnlc_pkg::BCD_W-1:0] bcd_adj;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        bcd_adj = in_data.bcd;
        for (int i = 0; i < cnlc_pkg::NUM_DIGITS; i++)
        begin
            // add 3 to any digit of five or more before the doubling shift
            if (in_data.bcd[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = in_data.bcd[4*i +: 4] + 4'd3;
            end
        end
        data_next.bcd = {bcd_adj[cnlc_pkg::BCD_W-2:0], in_data.bin[cnlc_pkg::IN_W-1]};
        data_next.bin = {in_data.bin[cnlc_pkg::IN_W-2:0], 1'b0};
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/cnlc_eval.sv
// Luhn sum tree, digit count and prefix decode over the converted digits.
module cnlc_eval (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cnlc_pkg::BCD_W-1:0] bcd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cnlc_pkg::result_t          result
);

    localparam int NGRP = (cnlc_pkg::NUM_DIGITS + 3) / 4;

    // Doubled digit folded back to one digit
    function automatic logic [3:0] luhn_map(input logic [3:0] d);
        logic [4:0] dd;
        dd = {d, 1'b0};
        if (dd > 5'd9)
        begin
            dd = dd - 5'd9;
        end
        return dd[3:0];
    endfunction

    function automatic logic is_mult10(input logic [7:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 26; k++)
        begin
            if (s == 8'(k * 10))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // first stage: group sums, count, prefix flags
    logic                       s1_valid_reg;
    logic                       s1_ready;
    logic [5:0]                 grp_reg  [NGRP];
    logic [5:0]                 grp_next [NGRP];
    logic [cnlc_pkg::CNT_W-1:0] cnt_reg;
    logic [cnlc_pkg::CNT_W-1:0] cnt_next;
    logic [3:0]                 flag_reg;
    logic [3:0]                 flag_next;

    // second stage: output register
    logic                       out_valid_reg;
    cnlc_pkg::result_t          res_reg;
    cnlc_pkg::result_t          res_next;
    logic [7:0]                 total;

    assign s1_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    always_comb
    begin
        logic [3:0] d;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
        end
        cnt_next = '0;
        for (int i = 0; i < cnlc_pkg::NUM_DIGITS; i++)
        begin
            d = bcd[4*i +: 4];
            if (i % 2 == 1)
            begin
                grp_next[i/4] = grp_next[i/4] + 6'(luhn_map(d));
            end
            else
            begin
                grp_next[i/4] = grp_next[i/4] + 6'(d);
            end
            if (d != 4'd0)
            begin
                cnt_next = cnlc_pkg::CNT_W'(i + 1);
            end
        end
        // thirteen digits, leading 4
        flag_next[0] = bcd[4*12 +: 4] == 4'd4;
        // fifteen digits, leading 34 or 37
        flag_next[1] = (bcd[4*14 +: 4] == 4'd3)
                    && ((bcd[4*13 +: 4] == 4'd4) || (bcd[4*13 +: 4] == 4'd7));
        // sixteen digits, leading 4
        flag_next[2] = bcd[4*15 +: 4] == 4'd4;
        // sixteen digits, leading 51 through 55
        flag_next[3] = (bcd[4*15 +: 4] == 4'd5)
                    && (bcd[4*14 +: 4] >= 4'd1) && (bcd[4*14 +: 4] <= 4'd5);
    end

    always_comb
    begin
        logic pass;
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + 8'(grp_reg[g]);
        end
        pass = (cnt_reg != '0) && (cnt_reg <= cnlc_pkg::CNT_W'(cnlc_pkg::MAX_DIGITS))
            && is_mult10(total);
        res_next.luhn_pass   = pass;
        res_next.digit_count = cnt_reg;
        res_next.card_class  = cnlc_pkg::CLS_INVALID;
        if (pass)
        begin
            if ((cnt_reg == 5'd13 && flag_reg[0]) || (cnt_reg == 5'd16 && flag_reg[2]))
            begin
                res_next.card_class = cnlc_pkg::CLS_LEAD4;
            end
            else if (cnt_reg == 5'd15 && flag_reg[1])
            begin
                res_next.card_class = cnlc_pkg::CLS_LEAD3X;
            end
            else if (cnt_reg == 5'd16 && flag_reg[3])
            begin
                res_next.card_class = cnlc_pkg::CLS_LEAD5X;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            grp_reg  <= grp_next;
            cnt_reg  <= cnt_next;
            flag_reg <= flag_next;
        end
        if (s1_valid_reg && s1_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

FILE: src/card_number_luhn_classify_top.sv
// Top level of the card number Luhn check and class decoder.
//
// Usage:
//   Input channel s_*: one item per card number, a binary value of up to
//   17 decimal digits. Output channel m_*: exactly one result item per input
//   item, in order: Luhn pass flag, card class and decimal digit count.
//   The number passes through a chain of 54 shift-add-3 cells, one per input
//   bit, that builds 17 decimal digits; two evaluation stages then add the
//   Luhn-mapped digits in a registered tree, count digits and decode the
//   leading digits.
//   Path: the item passes 56 registers in line, the first loaded at acceptance.
//   Throughput: one item per cycle while m_tready is high; every cell and stage
//   hands its item on as it takes the next, so chain length sets latency, not rate.
//   Stall: when m_tready is low the output register holds its item; stages
//   behind it keep advancing into empty slots, so s_tready stays high until
//   the whole chain is full.
//   Reset: rst_n clears all valid flags at once, which leaves s_tready high so
//   the block is ready for an item. No data state survives between items.
module card_number_luhn_classify_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [53:0] card_number, [55:54] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] luhn_pass, [2:1] card_class, [7:3] digit_count
);

    localparam int NCELL = cnlc_pkg::IN_W;

    logic               cell_valid [NCELL+1];
    logic               cell_ready [NCELL+1];
    cnlc_pkg::dd_data_t cell_data  [NCELL+1];
    cnlc_pkg::result_t  result;

    // feed the chain: binary value, empty digits
    assign cell_valid[0]    = s_tvalid;
    assign s_tready         = cell_ready[0];
    assign cell_data[0].bin = s_tdata[cnlc_pkg::IN_W-1:0];
    assign cell_data[0].bcd = '0;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        cnlc_dd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[k]),
            .in_ready  (cell_ready[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_ready (cell_ready[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // digits are complete after the last cell; evaluate and hold the result
    cnlc_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[NCELL]),
        .in_ready  (cell_ready[NCELL]),
        .bcd       (cell_data[NCELL].bcd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = result;

    // a nonzero class only ever comes with a passing check
    a_class_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:1] != cnlc_pkg::CLS_INVALID) |-> m_tdata[0])
        else $error("card class set without Luhn pass");

    // a pass needs one to MAX_DIGITS digits
    a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            (m_tdata[7:3] != 5'd0) && (m_tdata[7:3] <= 5'(cnlc_pkg::MAX_DIGITS)))
        else $error("Luhn pass with impossible digit count");

    // the 5x and 3x class codes agree with their digit counts
    a_class_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[2:1] == cnlc_pkg::CLS_LEAD5X && m_tdata[7:3] != 5'd16)
            || (m_tdata[2:1] == cnlc_pkg::CLS_LEAD3X && m_tdata[7:3] != 5'd15)) |-> 1'b0)
        else $error("card class inconsistent with digit count");

    // a stalled result is kept
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

endmodule

FILE: tb/tb_card_number_luhn_classify_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the card number Luhn check and class decoder.
module tb_card_number_luhn_classify_top;

    // Cycles without any item moving on either side before the run is declared hung.
    // Longest legal quiet stretch is the long receiver hold-off (plus pipeline refill).
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS = 880;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned HOLD_AFTER   = 300;   // input items before the long hold-off
    localparam int unsigned TAIL_CYCLES  = 64;    // pipeline latency plus margin
    localparam longint unsigned NUM_MASK = (64'd1 << cnlc_pkg::IN_W) - 64'd1;

    typedef struct packed {
        logic [cnlc_pkg::IN_W-1:0] card;
        cnlc_pkg::result_t         res;
    } pending_t;

    // Predicts one result per accepted card number and checks results in order.
    class luhn_scoreboard;
        pending_t    pending_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Digit total with every second digit from the right doubled and folded.
        static function int unsigned luhn_total(longint unsigned value);
            int unsigned total;
            int unsigned d;
            int unsigned pos;
            total = 0;
            pos   = 0;
            while (value != 0)
            begin
                d = int'(value % 10);
                if (pos[0])
                begin
                    d = d * 2;
                    if (d > 9)
                        d = d - 9;
                end
                total += d;
                value /= 10;
                pos++;
            end
            return total;
        endfunction

        static function cnlc_pkg::result_t predict_card(logic [cnlc_pkg::IN_W-1:0] card);
            longint unsigned   value;
            int unsigned       digits[20];
            int unsigned       n;
            int unsigned       lead1;
            int unsigned       lead2;
            cnlc_pkg::result_t r;
            value = card;
            n     = 0;
            while (value != 0)
            begin
                digits[n] = int'(value % 10);
                value /= 10;
                n++;
            end
            r.digit_count = n[cnlc_pkg::CNT_W-1:0];
            r.luhn_pass   = (n > 0) && (n <= cnlc_pkg::MAX_DIGITS)
                            && (luhn_total(card) % 10 == 0);
            r.card_class  = cnlc_pkg::CLS_INVALID;
            if (r.luhn_pass)
            begin
                lead1 = digits[n-1];
                lead2 = (n >= 2) ? lead1 * 10 + digits[n-2] : lead1;
                if (lead1 == 4 && (n == 13 || n == 16))
                    r.card_class = cnlc_pkg::CLS_LEAD4;
                else if (n == 15 && (lead2 == 34 || lead2 == 37))
                    r.card_class = cnlc_pkg::CLS_LEAD3X;
                else if (n == 16 && lead2 >= 51 && lead2 <= 55)
                    r.card_class = cnlc_pkg::CLS_LEAD5X;
            end
            return r;
        endfunction

        function void note_card(logic [cnlc_pkg::IN_W-1:0] card);
            pending_t p;
            p.card = card;
            p.res  = predict_card(card);
            pending_q.push_back(p);
        endfunction

        function void check_result(cnlc_pkg::result_t got);
            pending_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %h arrived with no card pending", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.luhn_pass !== want.res.luhn_pass || got.card_class !== want.res.card_class
                || got.digit_count !== want.res.digit_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: card %0d: pass %b/%b class %0d/%0d digits %0d/%0d (exp/got)",
                             want.card, want.res.luhn_pass, got.luhn_pass,
                             want.res.card_class, got.card_class,
                             want.res.digit_count, got.digit_count);
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // [53:0] card_number, [55:54] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] luhn_pass, [2:1] card_class, [7:3] digit_count

    luhn_scoreboard sb;
    int unsigned    cards_sent = 0;   // input items accepted so far
    int unsigned    burst_left = 0;
    bit             pace_gaps  = 1'b0;
    int unsigned    idle_cycles = 0;

    card_number_luhn_classify_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Card number generators
    // ------------------------------------------------------------------

    // Random number with exactly len digits; a 17-digit number leads with 1
    // so that it usually fits the 54-bit field.
    function automatic longint unsigned random_digits(int unsigned len);
        longint unsigned value;
        value = (len == 17) ? 1 : $urandom_range(1, 9);
        repeat (len - 1)
            value = value * 10 + $urandom_range(0, 9);
        return value & NUM_MASK;
    endfunction

    // Number of len digits that starts with prefix and carries a correct check digit.
    function automatic longint unsigned luhn_card(int unsigned prefix, int unsigned prefix_len,
                                                  int unsigned len);
        longint unsigned value;
        int unsigned     i;
        value = prefix;
        for (i = prefix_len; i + 1 < len; i++)
            value = value * 10 + $urandom_range(0, 9);
        value = value * 10;
        // The check digit sits in an undoubled position, so it adds straight to the total
        return value + (10 - luhn_scoreboard::luhn_total(value) % 10) % 10;
    endfunction

    // Nudge the check digit so the Luhn test fails.
    function automatic longint unsigned spoil_check_digit(longint unsigned value);
        return (value % 10 == 9) ? value - 1 : value + 1;
    endfunction

    function automatic longint unsigned well_formed_card();
        case ($urandom_range(0, 5))
            0: return luhn_card(4, 1, 13);
            1: return luhn_card(4, 1, 16);
            2: return luhn_card($urandom_range(0, 1) ? 34 : 37, 2, 15);
            3: return luhn_card($urandom_range(51, 55), 2, 16);
            4: return luhn_card($urandom_range(30, 59), 2, $urandom_range(12, 16));
            default: return luhn_card($urandom_range(1, 9), 1, $urandom_range(2, 16));
        endcase
    endfunction

    // Mostly valid cards with random content, the rest broken or plain noise.
    function automatic longint unsigned random_card();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return well_formed_card();
        else if (pick < 70)
            return spoil_check_digit(well_formed_card());
        else if (pick < 85)
            return {$urandom, $urandom} & NUM_MASK;
        else
            return random_digits($urandom_range(1, 17));
    endfunction

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // Offer one card number and hold it until the block takes it. With pacing on,
    // items go out in bursts of random length separated by random gaps.
    task automatic send_card(longint unsigned value);
        int unsigned gap;
        if (pace_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, value[cnlc_pkg::IN_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        cards_sent++;
    endtask

    // Drop valid and stay quiet until every predicted result has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready pattern changes mode after each random span; one long
    // hold-off lets the pipeline fill so the input side must stall.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned phase;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        phase = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && cards_sent >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 64);
                repeat (span)
                begin
                    case (mode)
                        0: m_tready <= 1'b1;                         // no stalls
                        1: m_tready <= (phase[1:0] != 2'b11);        // one stall in four
                        2: m_tready <= 1'($urandom_range(0, 1));     // coin toss
                        default: m_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
                    endcase
                    phase++;
                    @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog: note accepted inputs, check accepted results,
    // and end the run if nothing moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(cnlc_pkg::result_t'(m_tdata));
            if (s_tvalid && s_tready)
                sb.note_card(s_tdata[cnlc_pkg::IN_W-1:0]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("card_number_luhn_classify_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        longint unsigned directed_cards[$];
        int unsigned     i;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Edges of the field, digit-count limits and every class boundary
        directed_cards.push_back(0);                            // no digits at all
        directed_cards.push_back(NUM_MASK);                     // all input bits set, 17 digits
        directed_cards.push_back(64'd9999999999999999);         // largest 16-digit value
        directed_cards.push_back(64'd10000000000000000);        // smallest 17-digit value
        directed_cards.push_back(luhn_card(10, 2, 17));         // check passes but too long
        directed_cards.push_back(luhn_card(4, 1, 13));
        directed_cards.push_back(luhn_card(4, 1, 16));
        directed_cards.push_back(luhn_card(34, 2, 15));
        directed_cards.push_back(luhn_card(37, 2, 15));
        directed_cards.push_back(luhn_card(51, 2, 16));
        directed_cards.push_back(luhn_card(55, 2, 16));
        directed_cards.push_back(luhn_card(4, 1, 15));          // right lead, wrong length
        directed_cards.push_back(luhn_card(4, 1, 12));
        directed_cards.push_back(luhn_card(50, 2, 16));         // just outside the 5x range
        directed_cards.push_back(luhn_card(56, 2, 16));
        directed_cards.push_back(luhn_card(35, 2, 15));
        directed_cards.push_back(luhn_card(34, 2, 16));
        directed_cards.push_back(luhn_card(51, 2, 15));
        directed_cards.push_back(spoil_check_digit(luhn_card(4, 1, 16)));   // check fails
        directed_cards.push_back(spoil_check_digit(luhn_card(37, 2, 15)));
        directed_cards.push_back(spoil_check_digit(luhn_card(53, 2, 16)));
        directed_cards.push_back(18);                           // short number that passes
        directed_cards.push_back(1);
        directed_cards.push_back(9);
        directed_cards.push_back(4);
        foreach (directed_cards[k])
            send_card(directed_cards[k]);
        wait_for_drain();

        // Random part: paced bursts, one unpaced stretch, one full drain midway
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 450)
                wait_for_drain();
            pace_gaps = !(i >= 600 && i < 700);
            send_card(random_card());
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("card_number_luhn_classify_top verification clean");
        else
            $display("card_number_luhn_classify_top verification failed");
        $finish;
    end

endmodule
